FILE: src/mofl_pkg.sv
// Package: shared types and constants for the motor overcurrent fault latch
`default_nettype none

package mofl_pkg;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] CSR_CURRENT_LIMIT    = 2'd0;
   localparam logic [1:0] CSR_TRIP_TIME_MS     = 2'd1;
   localparam logic [1:0] CSR_RECOVERY_TIME_MS = 2'd2;

   localparam logic [15:0] CURRENT_LIMIT_RESET    = 16'd0;
   localparam logic [15:0] TRIP_TIME_MS_RESET     = 16'd3;
   localparam logic [15:0] RECOVERY_TIME_MS_RESET = 16'd500;

   localparam logic [15:0] TIMER_MAX = 16'hFFFF;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_TRIP = 1'b1;

   localparam logic [3:0] FAULT_NONE           = 4'd0;
   localparam logic [3:0] FAULT_SW_OVERCURRENT = 4'd1;

   typedef struct packed {
      logic               operation;
      logic        [15:0] delta_ms;
      logic signed [15:0] current_a;
      logic signed [15:0] current_b;
      logic signed [15:0] current_c;
      logic               pwm_enabled;
      logic               control_active;
      logic               hw_fail_pending;
      logic        [3:0]  trip_code;
   } req_type;

   typedef struct packed {
      logic [3:0]  fault_code;
      logic        tripped_now;
      logic        recovered_now;
      logic [15:0] over_time_ms;
      logic [15:0] safe_time_ms;
   } rsp_type;

   typedef struct packed {
      logic [15:0] current_limit;
      logic [15:0] trip_time_ms;
      logic [15:0] recovery_time_ms;
   } cfg_type;

   typedef struct packed {
      logic in_load;
      logic out_load;
   } ctrl_type;

   // magnitude of a 16-bit signed sample; -32768 maps to 32768
   function automatic logic [15:0] magnitude(input logic signed [15:0] value);
      logic [15:0] result;
      begin
         result = value[15] ? 16'(-value) : 16'(value);
         return result;
      end
   endfunction

endpackage

`default_nettype wire

FILE: src/mofl_csr.sv
// Configuration register file with APB-style access
`default_nettype none

module mofl_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [mofl_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire logic [mofl_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic      [mofl_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                       csr_pready,
   output mofl_pkg::cfg_type                          cfg
);

   mofl_pkg::cfg_type cfg_ff;
   mofl_pkg::cfg_type cfg_in;
   logic              write_en;
   logic [1:0]        index;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[3:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            mofl_pkg::CSR_CURRENT_LIMIT:    cfg_in.current_limit    = csr_pwdata[15:0];
            mofl_pkg::CSR_TRIP_TIME_MS:     cfg_in.trip_time_ms     = csr_pwdata[15:0];
            mofl_pkg::CSR_RECOVERY_TIME_MS: cfg_in.recovery_time_ms = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.current_limit    <= mofl_pkg::CURRENT_LIMIT_RESET;
         cfg_ff.trip_time_ms     <= mofl_pkg::TRIP_TIME_MS_RESET;
         cfg_ff.recovery_time_ms <= mofl_pkg::RECOVERY_TIME_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         mofl_pkg::CSR_CURRENT_LIMIT:    csr_prdata = 32'(cfg_ff.current_limit);
         mofl_pkg::CSR_TRIP_TIME_MS:     csr_prdata = 32'(cfg_ff.trip_time_ms);
         mofl_pkg::CSR_RECOVERY_TIME_MS: csr_prdata = 32'(cfg_ff.recovery_time_ms);
         default:                        csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: src/mofl_datapath.sv
// Input register, fault latch state update and result register
`default_nettype none

module mofl_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mofl_pkg::cfg_type  cfg,
   input  wire mofl_pkg::ctrl_type ctrl,
   input  wire mofl_pkg::req_type  req,
   output mofl_pkg::rsp_type       rsp
);

   mofl_pkg::req_type req_ff;
   mofl_pkg::rsp_type rsp_ff;
   mofl_pkg::rsp_type rsp_in;

   logic [3:0]  fault_ff,      fault_in;
   logic [15:0] over_timer_ff, over_timer_in;
   logic [15:0] safe_timer_ff, safe_timer_in;

   logic [15:0] mag_a, mag_b, mag_c, mag_ab, mag_max;
   logic        exceeded;
   logic [16:0] over_sum;
   logic [15:0] over_sat;
   logic [16:0] safe_sum;

   always_ff @(posedge clock) begin
      if (ctrl.in_load) begin
         req_ff <= req;
      end
   end

   always_comb begin
      mag_a    = mofl_pkg::magnitude(req_ff.current_a);
      mag_b    = mofl_pkg::magnitude(req_ff.current_b);
      mag_c    = mofl_pkg::magnitude(req_ff.current_c);
      mag_ab   = (mag_b > mag_a) ? mag_b : mag_a;
      mag_max  = (mag_c > mag_ab) ? mag_c : mag_ab;
      exceeded = (cfg.current_limit != 16'd0) && (mag_max > cfg.current_limit);
      over_sum = {1'b0, over_timer_ff} + {1'b0, req_ff.delta_ms};
      over_sat = over_sum[16] ? mofl_pkg::TIMER_MAX : over_sum[15:0];
      safe_sum = {1'b0, safe_timer_ff} + {1'b0, req_ff.delta_ms};
   end

   always_comb begin
      fault_in             = fault_ff;
      over_timer_in        = over_timer_ff;
      safe_timer_in        = safe_timer_ff;
      rsp_in.tripped_now   = 1'b0;
      rsp_in.recovered_now = 1'b0;
      priority if (req_ff.operation == mofl_pkg::OP_TRIP) begin
         fault_in           = req_ff.trip_code;
         over_timer_in      = '0;
         safe_timer_in      = '0;
         rsp_in.tripped_now = 1'b1;
      end else if (req_ff.delta_ms != 16'd0) begin
         if (fault_ff != mofl_pkg::FAULT_NONE) begin
            // recovery: count safe time while latched
            if (!req_ff.pwm_enabled && !req_ff.hw_fail_pending && !exceeded) begin
               if (safe_sum >= {1'b0, cfg.recovery_time_ms}) begin
                  fault_in             = mofl_pkg::FAULT_NONE;
                  safe_timer_in        = '0;
                  rsp_in.recovered_now = 1'b1;
               end else begin
                  safe_timer_in = safe_sum[15:0];
               end
            end else begin
               safe_timer_in = '0;
            end
         end else begin
            safe_timer_in = '0;
            if (!req_ff.control_active || !req_ff.pwm_enabled || !exceeded) begin
               over_timer_in = '0;
            end else if (over_sat >= cfg.trip_time_ms) begin
               fault_in           = mofl_pkg::FAULT_SW_OVERCURRENT;
               over_timer_in      = '0;
               rsp_in.tripped_now = 1'b1;
            end else begin
               over_timer_in = over_sat;
            end
         end
      end else begin
         // zero delta tick: state holds, no flags
      end
      rsp_in.fault_code   = fault_in;
      rsp_in.over_time_ms = over_timer_in;
      rsp_in.safe_time_ms = safe_timer_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff      <= mofl_pkg::FAULT_NONE;
         over_timer_ff <= '0;
         safe_timer_ff <= '0;
      end else if (ctrl.out_load) begin
         fault_ff      <= fault_in;
         over_timer_ff <= over_timer_in;
         safe_timer_ff <= safe_timer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

   a_trip_clears_timers: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load && rsp_in.tripped_now |=> over_timer_ff == 16'd0 && safe_timer_ff == 16'd0)
      else $error("timers not cleared on trip");

   a_recover_clears_latch: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load && rsp_in.recovered_now |=> fault_ff == mofl_pkg::FAULT_NONE)
      else $error("fault latch not cleared on recovery");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !ctrl.out_load |=> $stable(fault_ff) && $stable(over_timer_ff) && $stable(safe_timer_ff))
      else $error("state changed without a word");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load |-> !(rsp_in.tripped_now && rsp_in.recovered_now))
      else $error("trip and recover in one word");

endmodule

`default_nettype wire

FILE: src/motor_overcurrent_fault_latch_unit.sv
// Top level: handshake control, register file and fault latch datapath
// An accepted word passes from the input register to the result register, which
// rsp_valid flags. Throughput: one word per cycle while rsp_stall does not hold the
// result register; the fault latch and timers update once per word, in the single
// stage between the input register and the result register. Reset (synchronous):
// timers and fault latch cleared, registers to their defaults, both stages empty.
`default_nettype none

module motor_overcurrent_fault_latch_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire mofl_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output mofl_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [mofl_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [mofl_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic      [mofl_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                      csr_pready
);

   mofl_pkg::cfg_type  cfg;
   mofl_pkg::ctrl_type ctrl;

   logic in_valid_ff,  in_valid_in;
   logic out_valid_ff, out_valid_in;

   // the input stage moves on when the result register is empty or draining
   always_comb begin
      ctrl.out_load = in_valid_ff && (!out_valid_ff || !rsp_stall);
      req_stall     = in_valid_ff && !ctrl.out_load;
      ctrl.in_load  = req_valid && !req_stall;
      in_valid_in   = ctrl.in_load || (in_valid_ff && !ctrl.out_load);
      out_valid_in  = ctrl.out_load || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

   mofl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mofl_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .ctrl  (ctrl),
      .req   (req_data),
      .rsp   (rsp_data)
   );

endmodule

`default_nettype wire

FILE: verif/motor_overcurrent_fault_latch_unit_test.sv
// Testbench: directed and random stimulus for the overcurrent fault latch, checked word by word
module motor_overcurrent_fault_latch_unit_test;
   import mofl_pkg::*;

   // tracks the fault latch, both timers and the register values, and queues the status words
   class fault_latch_tracker;
      int unsigned current_limit = 32'(CURRENT_LIMIT_RESET);
      int unsigned trip_time = 32'(TRIP_TIME_MS_RESET);
      int unsigned recovery_time = 32'(RECOVERY_TIME_MS_RESET);
      int unsigned over_timer = 0;
      int unsigned safe_timer = 0;
      logic [3:0] latched = FAULT_NONE;
      rsp_type expected_status[$];
      int errors = 0;

      function void set_register(logic [1:0] idx, logic [15:0] value);
         case (idx)
            CSR_CURRENT_LIMIT: current_limit = 32'(value);
            CSR_TRIP_TIME_MS: trip_time = 32'(value);
            CSR_RECOVERY_TIME_MS: recovery_time = 32'(value);
            default: ;
         endcase
      endfunction

      // -32768 comes out as 32768, hence the extra bit
      function logic [16:0] magnitude17(logic signed [15:0] v);
         logic signed [16:0] s;
         s = 17'(v);
         return (s < 0) ? 17'(-s) : 17'(s);
      endfunction

      function void absorb_word(req_type w);
         rsp_type r;
         logic [16:0] peak;
         bit over_limit;
         int unsigned sum;
         peak = magnitude17(w.current_a);
         if (magnitude17(w.current_b) > peak) peak = magnitude17(w.current_b);
         if (magnitude17(w.current_c) > peak) peak = magnitude17(w.current_c);
         over_limit = (current_limit != 0) && (peak > current_limit);
         r = '0;
         if (w.operation == OP_TRIP) begin
            latched = w.trip_code;
            over_timer = 0;
            safe_timer = 0;
            r.tripped_now = 1'b1;
         end else if (w.delta_ms != 0) begin
            if (latched != FAULT_NONE) begin
               if (!w.pwm_enabled && !w.hw_fail_pending && !over_limit) begin
                  sum = safe_timer + 32'(w.delta_ms);
                  if (sum >= recovery_time) begin
                     latched = FAULT_NONE;
                     safe_timer = 0;
                     r.recovered_now = 1'b1;
                  end else begin
                     safe_timer = sum;
                  end
               end else begin
                  safe_timer = 0;
               end
            end else begin
               safe_timer = 0;
               if (!w.control_active || !w.pwm_enabled) begin
                  over_timer = 0;
               end else if (over_limit) begin
                  sum = over_timer + 32'(w.delta_ms);
                  over_timer = (sum > 32'(TIMER_MAX)) ? 32'(TIMER_MAX) : sum;
                  if (over_timer >= trip_time) begin
                     latched = FAULT_SW_OVERCURRENT;
                     over_timer = 0;
                     safe_timer = 0;
                     r.tripped_now = 1'b1;
                  end
               end else begin
                  over_timer = 0;
               end
            end
         end
         r.fault_code = latched;
         r.over_time_ms = over_timer[15:0];
         r.safe_time_ms = safe_timer[15:0];
         expected_status.push_back(r);
      endfunction

      function void compare_status(rsp_type got);
         rsp_type want;
         if (expected_status.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         want = expected_status.pop_front();
         if (got.fault_code !== want.fault_code) begin
            $display("%0t: fault_code expected %h actual %h", $time, want.fault_code,
                     got.fault_code);
            errors++;
         end
         if (got.tripped_now !== want.tripped_now) begin
            $display("%0t: tripped_now expected %b actual %b", $time, want.tripped_now,
                     got.tripped_now);
            errors++;
         end
         if (got.recovered_now !== want.recovered_now) begin
            $display("%0t: recovered_now expected %b actual %b", $time, want.recovered_now,
                     got.recovered_now);
            errors++;
         end
         if (got.over_time_ms !== want.over_time_ms) begin
            $display("%0t: over_time_ms expected %0d actual %0d", $time, want.over_time_ms,
                     got.over_time_ms);
            errors++;
         end
         if (got.safe_time_ms !== want.safe_time_ms) begin
            $display("%0t: safe_time_ms expected %0d actual %0d", $time, want.safe_time_ms,
                     got.safe_time_ms);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   fault_latch_tracker tracker = new();

   motor_overcurrent_fault_latch_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // values read here are the ones from before this edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) tracker.absorb_word(req_data);
      if (!reset && rsp_valid && !rsp_stall) tracker.compare_status(rsp_data);
   end

   // result side stall: random, or one long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 150;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic req_type make_tick(int elapsed, int a, int b, int c,
                                         bit pwm, bit ctrl, bit hw);
      req_type w;
      w = '0;
      w.operation = OP_TICK;
      w.delta_ms = 16'(elapsed);
      w.current_a = 16'(a);
      w.current_b = 16'(b);
      w.current_c = 16'(c);
      w.pwm_enabled = pwm;
      w.control_active = ctrl;
      w.hw_fail_pending = hw;
      return w;
   endfunction

   function automatic req_type make_trip(logic [3:0] code);
      req_type w;
      w = '0;
      w.operation = OP_TRIP;
      w.trip_code = code;
      return w;
   endfunction

   // called right after an edge; returns after the edge that takes the word, or later if it then idles
   task automatic send_word(req_type w);
      req_data <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_status.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      tracker.set_register(idx, value);
   endtask

   task automatic load_settings(logic [15:0] limit, logic [15:0] trip, logic [15:0] recovery);
      drain_results();
      write_register(CSR_CURRENT_LIMIT, limit);
      write_register(CSR_TRIP_TIME_MS, trip);
      write_register(CSR_RECOVERY_TIME_MS, recovery);
   endtask

   initial begin
      req_type w;
      logic [95:0] noise;
      int ph[3];
      int lim, cap, m, k, roll, span, mode, over_cut;
      logic [15:0] limit_value, trip_value, recovery_value;
      bit latched;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: limit 0 so currents never count
      send_word(make_tick(0, 100, 100, 100, 1, 1, 0));
      send_word(make_tick(65535, -32768, 32767, -1, 1, 1, 0));
      send_word(make_trip(4'd9));
      send_word(make_tick(499, 0, 0, 0, 0, 0, 0));
      send_word(make_tick(1, 0, 0, 0, 0, 0, 0));
      send_word(make_trip(4'd0));
      send_word(make_trip(4'd15));
      send_word(make_tick(600, 5, -5, 0, 0, 1, 0));

      load_settings(16'd100, 16'd3, 16'd10);
      send_word(make_tick(1, -32768, 0, 0, 1, 1, 0));
      send_word(make_tick(1, 0, 32767, 0, 1, 1, 0));
      send_word(make_tick(0, 0, 0, 500, 1, 1, 0));
      send_word(make_tick(1, 0, 0, -101, 1, 1, 0));
      send_word(make_tick(5, 0, 0, 0, 1, 0, 0));
      send_word(make_tick(4, 0, 0, 0, 0, 0, 0));
      send_word(make_tick(4, 0, 0, 0, 0, 0, 1));
      send_word(make_tick(4, 0, 0, 101, 0, 0, 0));
      send_word(make_tick(9, 100, -100, 100, 0, 1, 0));
      send_word(make_tick(1, 0, 0, 0, 0, 0, 0));
      send_word(make_tick(2, 200, 0, 0, 1, 0, 0));
      send_word(make_tick(2, 200, 0, 0, 1, 1, 0));
      send_word(make_tick(1, 100, 0, 0, 1, 1, 0));

      // saturating over time, then zero recovery time
      load_settings(16'd1, 16'd65535, 16'd0);
      send_word(make_tick(40000, -32768, 0, 0, 1, 1, 0));
      send_word(make_tick(40000, 2, 0, 0, 1, 1, 0));
      send_word(make_tick(1, 0, 0, 0, 0, 0, 0));

      load_settings(16'd65535, 16'd0, 16'd65535);
      send_word(make_tick(1, -32768, 32767, 0, 1, 1, 0));
      load_settings(16'd1, 16'd0, 16'd65535);
      send_word(make_tick(1, 2, 0, 0, 1, 1, 0));

      for (int phase = 0; phase < 24; phase++) begin
         mode = phase / 8;
         send_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 47 : 0;
         recv_idle_pct = (mode == 0) ? 47 : (mode == 1) ? 6 : 0;

         roll = $urandom_range(9);
         limit_value = (roll == 0) ? 16'd0 : (roll == 1) ? 16'd65535 :
                       (roll == 2) ? 16'd1 : 16'($urandom_range(1, 3000));
         roll = $urandom_range(19);
         trip_value = (roll == 0) ? 16'd65535 : (roll == 1) ? 16'd1 :
                      (roll == 2) ? 16'd0 : 16'($urandom_range(1, 20));
         roll = $urandom_range(19);
         recovery_value = (roll == 0) ? 16'd65535 : (roll == 1) ? 16'd1 :
                          (roll == 2) ? 16'd0 : 16'($urandom_range(2, 60));
         load_settings(limit_value, trip_value, recovery_value);
         span = $urandom_range(1, 8);

         for (int n = 0; n < 80; n++) begin
            // long result hold-off while words keep coming, so the block backs up
            if ((phase == 1 || phase == 9) && n == 20) hold_request = 1'b1;
            noise = {$urandom, $urandom, $urandom};
            w = noise[$bits(req_type)-1:0];
            latched = (tracker.latched != FAULT_NONE);
            if ($urandom_range(99) < 4) begin
               w.operation = OP_TRIP;
            end else begin
               w.operation = OP_TICK;
               roll = $urandom_range(99);
               if (roll < 5) w.delta_ms = '0;
               else if (roll < 88) w.delta_ms = 16'($urandom_range(1, span));
               if ($urandom_range(99) < 80) begin
                  if (latched) begin
                     w.pwm_enabled = 1'b0;
                     w.hw_fail_pending = 1'b0;
                  end else begin
                     w.pwm_enabled = 1'b1;
                     w.control_active = 1'b1;
                  end
               end
               lim = tracker.current_limit;
               cap = (lim > 32767) ? 32767 : lim;
               over_cut = latched ? 60 : 25;
               roll = $urandom_range(99);
               if (roll < 75) begin
                  for (k = 0; k < 3; k++) begin
                     ph[k] = $urandom_range(0, cap);
                     if ($urandom_range(1)) ph[k] = -ph[k];
                  end
                  if (roll >= over_cut && lim < 32768) begin
                     m = lim + 1 + $urandom_range(0, 20);
                     if (m > 32768) m = 32768;
                     k = $urandom_range(2);
                     ph[k] = (m == 32768 || $urandom_range(1)) ? -m : m;
                  end
                  w.current_a = 16'(ph[0]);
                  w.current_b = 16'(ph[1]);
                  w.current_c = 16'(ph[2]);
               end
            end
            send_word(w);
         end
      end

      drain_results();
      if (tracker.errors == 0 && tracker.expected_status.size() == 0) begin
         $display("PASS motor_overcurrent_fault_latch_unit");
      end else begin
         $display("FAIL motor_overcurrent_fault_latch_unit");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL motor_overcurrent_fault_latch_unit");
      $finish;
   end

endmodule

FILE: motor_overcurrent_fault_latch_unit.f
src/mofl_pkg.sv
src/mofl_csr.sv
src/mofl_datapath.sv
src/motor_overcurrent_fault_latch_unit.sv
verif/motor_overcurrent_fault_latch_unit_test.sv
